@@ sv/lms_fir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS adaptive FIR package
// Shared types, constants and fixed-point helpers for the LMS filter core.
// ----------------------------------------------------------------------------
package lms_fir_pkg;

   localparam int DEF_NUM_TAPS = 32;

   localparam int SAMPLE_W = 16;
   localparam int VALUE_W  = 32;
   localparam int PROD_W   = 48;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index codes (paddr[2])
   localparam logic [0:0] REG_STEP_SIZE = 1'b0;

   localparam logic [SAMPLE_W-1:0] STEP_SIZE_RESET = 16'd655;

   typedef struct packed {
      logic hist_we;
      logic w_we;
   } store_ctl_type;

   // round to nearest (ties up) and drop 16 fraction bits of a product
   function automatic logic signed [VALUE_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] tmp;
      tmp = p + PROD_W'(32768);
      return tmp[PROD_W-1:16];
   endfunction

   // clamp a 33-bit value to the signed 32-bit range
   function automatic logic signed [VALUE_W-1:0] sat33(input logic signed [VALUE_W:0] v);
      logic signed [VALUE_W-1:0] r;
      if (v[VALUE_W] != v[VALUE_W-1]) begin
         r = v[VALUE_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ sv/lms_fir_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS FIR shared multiplier
// Signed 32-bit by unsigned 16-bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module lms_fir_mult (
   input  logic                                       clock,
   input  logic signed [lms_fir_pkg::VALUE_W-1:0]     op_a,
   input  logic        [lms_fir_pkg::SAMPLE_W-1:0]    op_b,
   output logic signed [lms_fir_pkg::PROD_W-1:0]      prod
);
   import lms_fir_pkg::*;

   logic signed [VALUE_W+SAMPLE_W:0] full_prod;
   logic signed [PROD_W-1:0]         prod_in;
   logic signed [PROD_W-1:0]         prod_ff;

   // magnitude stays below 2^47, so 48 bits hold it exactly
   assign full_prod = op_a * $signed({1'b0, op_b});
   assign prod_in   = full_prod[PROD_W-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ sv/lms_fir_tap_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS FIR tap store
// Sample history ring and weight memory, each with per-entry valid bits so
// that entries not yet written read as zero after reset.
// ----------------------------------------------------------------------------
module lms_fir_tap_store #(
   parameter int NUM_TAPS = lms_fir_pkg::DEF_NUM_TAPS,
   parameter int IDX_W    = $clog2(NUM_TAPS)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lms_fir_pkg::store_ctl_type              ctl,
   input  logic [IDX_W-1:0]                        hist_waddr,
   input  logic [lms_fir_pkg::SAMPLE_W-1:0]        hist_wdata,
   input  logic [IDX_W-1:0]                        hist_raddr,
   input  logic [IDX_W-1:0]                        w_waddr,
   input  logic signed [lms_fir_pkg::VALUE_W-1:0]  w_wdata,
   input  logic [IDX_W-1:0]                        w_raddr,
   output logic [lms_fir_pkg::SAMPLE_W-1:0]        x_rd,
   output logic signed [lms_fir_pkg::VALUE_W-1:0]  w_rd
);
   import lms_fir_pkg::*;

   logic [SAMPLE_W-1:0]       hist_mem_ff [NUM_TAPS];
   logic signed [VALUE_W-1:0] w_mem_ff    [NUM_TAPS];
   logic [NUM_TAPS-1:0]       hist_vld_ff;
   logic [NUM_TAPS-1:0]       w_vld_ff;
   logic [SAMPLE_W-1:0]       x_raw_ff;
   logic signed [VALUE_W-1:0] w_raw_ff;
   logic                      x_vld_ff;
   logic                      w_rvld_ff;

   always_ff @(posedge clock) begin
      if (ctl.hist_we) begin
         hist_mem_ff[hist_waddr] <= hist_wdata;
      end
      if (ctl.w_we) begin
         w_mem_ff[w_waddr] <= w_wdata;
      end
      x_raw_ff <= hist_mem_ff[hist_raddr];
      w_raw_ff <= w_mem_ff[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         w_vld_ff    <= '0;
         x_vld_ff    <= 1'b0;
         w_rvld_ff   <= 1'b0;
      end else begin
         if (ctl.hist_we) begin
            hist_vld_ff[hist_waddr] <= 1'b1;
         end
         if (ctl.w_we) begin
            w_vld_ff[w_waddr] <= 1'b1;
         end
         x_vld_ff  <= hist_vld_ff[hist_raddr];
         w_rvld_ff <= w_vld_ff[w_raddr];
      end
   end

   assign x_rd = x_vld_ff  ? x_raw_ff : '0;
   assign w_rd = w_rvld_ff ? w_raw_ff : '0;

endmodule

@@ sv/lms_adaptive_fir_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS adaptive FIR core
// Each input runs two sweeps over the taps, a filter sweep and a weight
// update sweep, through the one shared multiplier and the tap memories; a
// new input is accepted only once the update sweep is done.
// A stalled result holds the sequencer before the weight update sweep.
// Reset (synchronous): step_size = 655, history and weights read as zero.
// ----------------------------------------------------------------------------
module lms_adaptive_fir_core #(
   parameter int NUM_TAPS = lms_fir_pkg::DEF_NUM_TAPS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata: [15:0] ref_sample, [31:16] desired_sample
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [31:0]                             req_tdata,
   input  logic                                    req_tlast,   // frame_last
   // rsp_tdata: [31:0] error_value, [63:32] filter_output
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [63:0]                             rsp_tdata,
   output logic                                    rsp_tlast,   // last_out
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [lms_fir_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lms_fir_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lms_fir_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                    csr_pready
);
   import lms_fir_pkg::*;

   localparam int IDX_W = $clog2(NUM_TAPS);
   localparam int CNT_W = $clog2(NUM_TAPS + 1);
   localparam int ACC_W = PROD_W + IDX_W;
   localparam int YW    = ACC_W - 16;

   localparam logic signed [YW-1:0] Y_HI = YW'(32'sh7FFFFFFF);
   localparam logic signed [YW-1:0] Y_LO = YW'(32'sh80000000);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACC  = 3'd1;
   localparam logic [2:0] ST_FINY = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;
   localparam logic [2:0] ST_MULT = 3'd4;
   localparam logic [2:0] ST_TCAP = 3'd5;
   localparam logic [2:0] ST_UPD  = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [IDX_W-1:0]          rptr_ff, rptr_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rd_vld_ff, mul_vld_ff;
   logic [IDX_W-1:0]          idx1_ff, idx2_ff;
   logic signed [VALUE_W-1:0] w_hold_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [SAMPLE_W-1:0]       d_ff, d_in;
   logic                      last_ff, last_in;
   logic signed [VALUE_W-1:0] y_ff, y_in;
   logic signed [VALUE_W-1:0] e_ff, e_in;
   logic signed [VALUE_W-1:0] t_ff, t_in;
   logic [SAMPLE_W-1:0]       step_ff, step_in;
   logic [63:0]               rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_vld_ff, rsp_vld_in;

   logic                      req_acc;
   logic                      issuing;
   logic                      drained;
   logic                      rsp_load;
   logic [IDX_W-1:0]          hp_new;
   logic [IDX_W-1:0]          rptr_next;
   store_ctl_type             store_ctl;
   logic [SAMPLE_W-1:0]       x_rd;
   logic signed [VALUE_W-1:0] w_rd;
   logic signed [VALUE_W-1:0] op_a;
   logic [SAMPLE_W-1:0]       op_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   acc_rnd;
   logic signed [YW-1:0]      y_wide;
   logic signed [VALUE_W-1:0] e_new;
   logic signed [VALUE_W-1:0] upd_delta;
   logic signed [VALUE_W-1:0] w_new;
   logic                      csr_wr;

   // ---------------- datapath units ----------------
   lms_fir_tap_store #(
      .NUM_TAPS (NUM_TAPS),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (store_ctl),
      .hist_waddr (hp_new),
      .hist_wdata (req_tdata[15:0]),
      .hist_raddr (rptr_ff),
      .w_waddr    (idx2_ff),
      .w_wdata    (w_new),
      .w_raddr    (cnt_ff[IDX_W-1:0]),
      .x_rd       (x_rd),
      .w_rd       (w_rd)
   );

   lms_fir_mult u_mult (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   always_comb begin
      case (state_ff)
         ST_ACC:  begin
            op_a = w_rd;
            op_b = x_rd;
         end
         ST_MULT: begin
            op_a = e_ff;
            op_b = step_ff;
         end
         default: begin
            op_a = t_ff;
            op_b = x_rd;
         end
      endcase
   end

   // ---------------- control ----------------
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign issuing    = ((state_ff == ST_ACC) || (state_ff == ST_UPD)) &&
                       (cnt_ff != CNT_W'(NUM_TAPS));
   assign drained    = !issuing && !rd_vld_ff && !mul_vld_ff;
   assign rsp_load   = (state_ff == ST_EMIT) && (!rsp_vld_ff || rsp_tready);
   assign hp_new     = (head_ff == '0) ? IDX_W'(NUM_TAPS - 1) : head_ff - 1'b1;
   assign rptr_next  = (rptr_ff == IDX_W'(NUM_TAPS - 1)) ? '0 : rptr_ff + 1'b1;

   assign store_ctl.hist_we = req_acc;
   assign store_ctl.w_we    = (state_ff == ST_UPD) && mul_vld_ff;

   assign acc_rnd   = acc_ff + ACC_W'(32768);
   assign y_wide    = acc_rnd[ACC_W-1:16];
   assign e_new     = sat33($signed({9'b0, d_ff, 8'b0}) - $signed({y_ff[VALUE_W-1], y_ff}));
   assign upd_delta = rnd_prod(prod);
   assign w_new     = sat33($signed({w_hold_ff[VALUE_W-1], w_hold_ff}) +
                            $signed({upd_delta[VALUE_W-1], upd_delta}));

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      rptr_in     = rptr_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      d_in        = d_ff;
      last_in     = last_ff;
      y_in        = y_ff;
      e_in        = e_ff;
      t_in        = t_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;

      if (issuing) begin
         cnt_in  = cnt_ff + 1'b1;
         rptr_in = rptr_next;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               head_in  = hp_new;
               rptr_in  = hp_new;
               cnt_in   = '0;
               acc_in   = '0;
               d_in     = req_tdata[31:16];
               last_in  = req_tlast;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (mul_vld_ff) begin
               acc_in = acc_ff + ACC_W'(prod);
            end
            if (drained) begin
               state_in = ST_FINY;
            end
         end
         ST_FINY: begin
            if (y_wide > Y_HI) begin
               y_in = 32'sh7FFFFFFF;
            end else if (y_wide < Y_LO) begin
               y_in = 32'sh80000000;
            end else begin
               y_in = y_wide[VALUE_W-1:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (rsp_load) begin
               rsp_data_in = {y_ff, e_new};
               rsp_last_in = last_ff;
               rsp_vld_in  = 1'b1;
               e_in        = e_new;
               state_in    = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_TCAP;
         end
         ST_TCAP: begin
            t_in     = rnd_prod(prod);
            cnt_in   = '0;
            rptr_in  = head_ff;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (drained) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         rptr_ff    <= '0;
         cnt_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         rptr_ff    <= rptr_in;
         cnt_ff     <= cnt_in;
         rd_vld_ff  <= issuing;
         mul_vld_ff <= rd_vld_ff;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload and pipeline alignment registers
   always_ff @(posedge clock) begin
      idx1_ff     <= cnt_ff[IDX_W-1:0];
      idx2_ff     <= idx1_ff;
      w_hold_ff   <= w_rd;
      acc_ff      <= acc_in;
      d_ff        <= d_in;
      last_ff     <= last_in;
      y_ff        <= y_in;
      e_ff        <= e_in;
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- register port ----------------
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_STEP_SIZE);
   assign step_in    = csr_wr ? csr_pwdata[SAMPLE_W-1:0] : step_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_STEP_SIZE) ?
                       {{(CSR_DATA_W - SAMPLE_W){1'b0}}, step_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_SIZE_RESET;
      end else begin
         step_ff <= step_in;
      end
   end

   // ---------------- assertions ----------------
   a_wwe_in_upd: assert property (@(posedge clock) disable iff (reset)
      store_ctl.w_we |-> (state_ff == ST_UPD))
      else $error("weight write outside update sweep");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_ACC) && (cnt_ff == '0))
      else $error("accepted transaction did not start accumulation");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      !(cnt_ff > CNT_W'(NUM_TAPS)))
      else $error("tap counter out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_tready && (state_ff == ST_EMIT)) |=> (state_ff == ST_EMIT))
      else $error("result loaded over a pending transaction");

endmodule

@@ tb/tb_lms_adaptive_fir_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS adaptive FIR core testbench
// Streams reference/desired sample pairs into the core and predicts every
// result with its own fixed-point copy of the delay line and the tap weights.
// Each result is compared field by field with the oldest prediction. The step
// size is rewritten between phases while the core is idle. Both stream sides
// stall in random bursts, and once the result side holds off long enough to
// back the core up.
// ----------------------------------------------------------------------------
module tb_lms_adaptive_fir_core;
   import lms_fir_pkg::*;

   localparam int NUM_TAPS         = DEF_NUM_TAPS;
   localparam int NUM_PHASES       = 8;
   localparam int ITEMS_PER_PHASE  = 180;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES    = 2 * NUM_TAPS + 16;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int MAX_PRINTED      = 100;

   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   localparam logic [CSR_ADDR_W-1:0] STEP_SIZE_ADDR = {REG_STEP_SIZE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR     = {~REG_STEP_SIZE, 2'b00};

   typedef struct {
      logic signed [VALUE_W-1:0] error_value;
      logic signed [VALUE_W-1:0] filter_output;
      logic                      last_out;
   } lms_result_type;

   class lms_tap_predictor;
      logic [SAMPLE_W-1:0]       step_size;
      logic [SAMPLE_W-1:0]       history [NUM_TAPS];
      logic signed [VALUE_W-1:0] weights [NUM_TAPS];
      lms_result_type            pending_results [$];
      int                        results_seen;
      int                        railed_results;
      int                        mismatches;

      function new();
         step_size = STEP_SIZE_RESET;
         foreach (history[i]) begin
            history[i] = '0;
            weights[i] = '0;
         end
         results_seen   = 0;
         railed_results = 0;
         mismatches     = 0;
      endfunction

      // floor((v + 2^15) / 2^16): nearest, ties up
      function longint round16(longint v);
         return (v + 32768) >>> 16;
      endfunction

      function logic signed [VALUE_W-1:0] clamp32(longint v);
         if (v > VALUE_MAX) return 32'sh7FFFFFFF;
         if (v < VALUE_MIN) return 32'sh80000000;
         return v[VALUE_W-1:0];
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
         if (addr[CSR_ADDR_W-1:2] == REG_STEP_SIZE) step_size = value[SAMPLE_W-1:0];
      endfunction

      function void take_sample(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] d, logic last);
         longint         acc;
         longint         scaled_err;
         longint         delta;
         lms_result_type r;
         acc = 0;
         for (int i = NUM_TAPS - 1; i > 0; i--) history[i] = history[i - 1];
         history[0] = x;
         foreach (weights[i]) acc += longint'(weights[i]) * longint'(history[i]);
         r.filter_output = clamp32(round16(acc));
         r.error_value   = clamp32(longint'(d) * 256 - longint'(r.filter_output));
         r.last_out      = last;
         // adapt with the shifted delay line
         scaled_err = round16(longint'(r.error_value) * longint'(step_size));
         foreach (weights[i]) begin
            delta      = round16(scaled_err * longint'(history[i]));
            weights[i] = clamp32(longint'(weights[i]) + delta);
         end
         pending_results.push_back(r);
      endfunction

      task flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
         mismatches++;
         // keep the log short on a badly broken build
         if (mismatches <= MAX_PRINTED)
            $display("%0t ns result %0d: %s is %h, want %h", $time, results_seen, field, got,
                     want);
      endtask

      task compare_output(logic [63:0] data, logic last);
         lms_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            flag_mismatch("result with no input pending", data[31:0], '0);
            return;
         end
         want = pending_results.pop_front();
         if (data[31:0] !== want.error_value)
            flag_mismatch("error_value", data[31:0], want.error_value);
         if (data[63:32] !== want.filter_output)
            flag_mismatch("filter_output", data[63:32], want.filter_output);
         if (last !== want.last_out)
            flag_mismatch("last_out", {31'b0, last}, {31'b0, want.last_out});
         if (want.filter_output == 32'sh7FFFFFFF || want.filter_output == 32'sh80000000)
            railed_results++;
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;   // [15:0] ref_sample, [31:16] desired_sample
   logic                  req_tlast = 1'b0; // frame_last
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [63:0]           rsp_tdata;        // [31:0] error_value, [63:32] filter_output
   logic                  rsp_tlast;        // last_out
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic req_idle_on = 1'b0;
   logic rsp_idle_on = 1'b0;
   logic hold_rsp = 1'b0;
   int   pairs_sent = 0;
   int   frame_ends = 0;
   int   step_loads = 0;

   lms_tap_predictor predictor = new();

   lms_adaptive_fir_core #(
      .NUM_TAPS(NUM_TAPS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_pair(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] d,
                            input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= {d, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predictor.take_sample(x, d, last);
      pairs_sent++;
      if (last) frame_ends++;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      predictor.write_reg(addr, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits are junk: the register keeps only its low 16
   task automatic load_step(input logic [SAMPLE_W-1:0] step);
      csr_write(STEP_SIZE_ADDR, {16'($urandom), step});
      step_loads++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (predictor.pending() != 0) @(posedge clock);
      // the weight update sweep runs on after the last result
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) predictor.compare_output(rsp_tdata, rsp_tlast);
   end

   initial begin : rsp_side
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] d;
      logic [SAMPLE_W-1:0] prev_x;
      logic [SAMPLE_W-1:0] step;
      int                  p;
      int                  n;
      prev_x = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a write to the spare address must leave the step size alone
      csr_write(SPARE_ADDR, $urandom);

      // corner samples at the reset step size
      send_pair(16'h0000, 16'h0000, 1'b0);
      send_pair(16'hFFFF, 16'hFFFF, 1'b1);
      send_pair(16'hFFFF, 16'h0000, 1'b0);
      send_pair(16'h0000, 16'hFFFF, 1'b0);
      send_pair(16'h0001, 16'h0001, 1'b1);
      send_pair(16'h8000, 16'h7FFF, 1'b0);
      send_pair(16'h5555, 16'hAAAA, 1'b0);
      send_pair(16'hAAAA, 16'h5555, 1'b1);
      send_pair(16'hFFFF, 16'hFFFF, 1'b0);
      send_pair(16'h7FFF, 16'h8000, 1'b1);

      // full step size makes the loop diverge into the rails on both sides
      wait_idle();
      load_step(16'hFFFF);
      repeat (6) send_pair(16'hFFFF, 16'hFFFF, 1'b0);
      repeat (6) send_pair(16'hFFFF, 16'h0000, 1'b1);

      for (p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         case (p)
            0: step = SAMPLE_W'($urandom_range(6000, 9000));
            1: step = 16'h0000;
            2: step = 16'h0001;
            3: step = 16'hFFFF;
            4: step = 16'd8000;
            5: step = SAMPLE_W'($urandom_range(0, 65535));
            6: step = SAMPLE_W'($urandom_range(2000, 9000));
            default: step = STEP_SIZE_RESET;
         endcase
         if (p == 3) csr_write(SPARE_ADDR, $urandom);
         load_step(step);
         req_idle_on = (p != 0) && (p != NUM_PHASES - 1) && (p % 3 != 2);
         rsp_idle_on = (p != NUM_PHASES - 1) && (p % 3 != 2);
         // back the core up while the sender keeps offering
         if (p == 0) hold_rsp = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            x = pick_sample();
            // mostly a two-tap plant the filter can learn, else noise
            if ($urandom_range(0, 3) != 0) d = SAMPLE_W'((17'(x) + 17'(prev_x)) >> 1);
            else d = pick_sample();
            prev_x = x;
            send_pair(x, d, $urandom_range(0, 7) == 0);
         end
      end

      wait_idle();
      $display("Covered %0d sample pairs with %0d frame ends over %0d step size loads;",
               pairs_sent, frame_ends, step_loads);
      $display("%0d results compared, %0d with the filter output at a rail.",
               predictor.results_seen, predictor.railed_results);
      if (predictor.mismatches == 0 && predictor.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
